[design/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam logic [20:0] CP_REPL    = 21'h00FFFD;
    localparam logic [20:0] CP_MIN2    = 21'h000080;
    localparam logic [20:0] CP_MIN3    = 21'h000800;
    localparam logic [20:0] CP_MIN4    = 21'h010000;
    localparam logic [20:0] CP_SURR_LO = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Results caused by one byte: rep_cnt replacements, then an optional tail.
    typedef struct packed {
        logic [2:0]  rep_cnt;
        logic        has_tail;
        logic [20:0] tail_cp;
        logic        tail_eot;
    } run_desc_t;

    typedef struct packed {
        logic      push;
        run_desc_t desc;
    } q_push_t;

    typedef struct packed {
        logic      nonempty;
        logic      full;
        run_desc_t head;
    } q_stat_t;

    function automatic logic [20:0] min_for_len(input logic [1:0] len);
        logic [20:0] m;
        unique case (len)
            2'd1:    m = CP_MIN2;
            2'd2:    m = CP_MIN3;
            2'd3:    m = CP_MIN4;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

[design/utf8d_if.sv]
// ----------------------------------------------------------------------------
// utf8d_if
// Valid/ready channels of the decoder: byte input and code point output.
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface utf8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        end_of_text;
    logic        last_of_run;

    modport source (output valid, output code_point, output end_of_text,
                    output last_of_run, input ready);
    modport sink   (input valid, input code_point, input end_of_text,
                    input last_of_run, output ready);
endinterface

[design/utf8d_front.sv]
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, tracks the open sequence and classifies each byte into a
// run of results.
// ----------------------------------------------------------------------------
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    utf8d_byte_if.sink   in_ch,
    input  q_stat_t      q_stat,
    output q_push_t      q_push
);

    logic [1:0]  exp_reg, exp_next;
    logic [1:0]  held_reg, held_next;
    logic [20:0] pv_reg, pv_next;

    logic        accept;
    logic [7:0]  b;
    run_desc_t   desc;

    // decode of the byte as if idle
    logic        fr_tail;
    logic [20:0] fr_cp;
    logic [1:0]  fr_exp;
    logic [20:0] fr_pv;

    logic [20:0] acc_pv;
    logic [1:0]  held_inc;
    logic        cp_bad;

    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.byte_in;

    always_comb
    begin
        fr_tail = 1'b0;
        fr_cp   = CP_REPL;
        fr_exp  = 2'd0;
        fr_pv   = '0;
        if (!b[7])
        begin
            fr_tail = 1'b1;
            fr_cp   = {13'd0, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            fr_exp = 2'd1;
            fr_pv  = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            fr_exp = 2'd2;
            fr_pv  = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            fr_exp = 2'd3;
            fr_pv  = {18'd0, b[2:0]};
        end
        else
        begin
            fr_tail = 1'b1;
        end
    end

    assign acc_pv   = {pv_reg[14:0], b[5:0]};
    assign held_inc = held_reg + 2'd1;
    assign cp_bad   = (acc_pv < min_for_len(exp_reg))
                   || ((acc_pv >= CP_SURR_LO) && (acc_pv <= CP_SURR_HI))
                   || (acc_pv > CP_MAX);

    always_comb
    begin
        exp_next  = exp_reg;
        held_next = held_reg;
        pv_next   = pv_reg;
        desc      = '0;
        if (b == 8'd0)
        begin
            desc.rep_cnt  = (exp_reg != 2'd0) ? ({1'b0, held_reg} + 3'd1) : 3'd0;
            desc.has_tail = 1'b1;
            desc.tail_cp  = '0;
            desc.tail_eot = 1'b1;
            exp_next      = 2'd0;
            held_next     = 2'd0;
            pv_next       = '0;
        end
        else if (exp_reg == 2'd0)
        begin
            desc.has_tail = fr_tail;
            desc.tail_cp  = fr_cp;
            exp_next      = fr_exp;
            held_next     = 2'd0;
            pv_next       = fr_pv;
        end
        else if (b[7:6] == 2'b10)
        begin
            if (held_inc == exp_reg)
            begin
                if (cp_bad)
                begin
                    desc.rep_cnt = {1'b0, exp_reg} + 3'd1;
                end
                else
                begin
                    desc.has_tail = 1'b1;
                    desc.tail_cp  = acc_pv;
                end
                exp_next  = 2'd0;
                held_next = 2'd0;
                pv_next   = '0;
            end
            else
            begin
                held_next = held_inc;
                pv_next   = acc_pv;
            end
        end
        else
        begin
            // broken sequence: flush lead and held bytes, then restart on b
            desc.rep_cnt  = {1'b0, held_reg} + 3'd1;
            desc.has_tail = fr_tail;
            desc.tail_cp  = fr_cp;
            exp_next      = fr_exp;
            held_next     = 2'd0;
            pv_next       = fr_pv;
        end
    end

    assign q_push.push = accept && ((desc.rep_cnt != 3'd0) || desc.has_tail);
    assign q_push.desc = desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= 2'd0;
            held_reg <= 2'd0;
            pv_reg   <= '0;
        end
        else if (accept)
        begin
            exp_reg  <= exp_next;
            held_reg <= held_next;
            pv_reg   <= pv_next;
        end
    end

    a_held_below_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg != 2'd0) |-> (held_reg < exp_reg))
        else $error("held count reached expected count");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (exp_reg == 2'd0) |-> (held_reg == 2'd0))
        else $error("held bytes while idle");

endmodule

[design/utf8d_queue.sv]
// ----------------------------------------------------------------------------
// utf8d_queue
// Small FIFO of result runs between front and back.
// ----------------------------------------------------------------------------
module utf8d_queue
    import utf8d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t q_push,
    input  logic    pop,
    output q_stat_t q_stat
);

    run_desc_t         entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_stat.nonempty = (cnt_reg != '0);
    assign q_stat.full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_stat.head     = entry_reg[rd_ptr_reg];
    assign do_pop          = pop && q_stat.nonempty;

    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (q_push.push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (q_push.push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!q_push.push && do_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push |-> !q_stat.full)
        else $error("push into full queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

endmodule

[design/utf8d_back.sv]
// ----------------------------------------------------------------------------
// utf8d_back
// Expands each result run into single output items, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    output logic        pop,
    utf8d_cp_if.source  out_ch
);

    logic        cur_valid_reg;
    logic [2:0]  rep_left_reg;
    logic        has_tail_reg;
    logic [20:0] tail_cp_reg;
    logic        tail_eot_reg;

    logic        fire;
    logic        last;

    assign last = (rep_left_reg == 3'd0) || ((rep_left_reg == 3'd1) && !has_tail_reg);
    assign fire = out_ch.valid && out_ch.ready;
    assign pop  = q_stat.nonempty && (!cur_valid_reg || (fire && last));

    assign out_ch.valid       = cur_valid_reg;
    assign out_ch.code_point  = (rep_left_reg != 3'd0) ? CP_REPL : tail_cp_reg;
    assign out_ch.end_of_text = (rep_left_reg == 3'd0) && tail_eot_reg;
    assign out_ch.last_of_run = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rep_left_reg  <= 3'd0;
            has_tail_reg  <= 1'b0;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            rep_left_reg  <= q_stat.head.rep_cnt;
            has_tail_reg  <= q_stat.head.has_tail;
        end
        else if (fire)
        begin
            if (last)
            begin
                cur_valid_reg <= 1'b0;
            end
            else
            begin
                rep_left_reg <= rep_left_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tail_cp_reg  <= q_stat.head.tail_cp;
            tail_eot_reg <= q_stat.head.tail_eot;
        end
    end

    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (rep_left_reg <= 3'd4))
        else $error("replacement count out of range");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last) |=> cur_valid_reg)
        else $error("run dropped before its last item");

endmodule

[design/utf8_validating_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_validating_decoder
// UTF-8 decoder with U+FFFD replacement; front classifier, run queue and
// back expander.
// ----------------------------------------------------------------------------
// A byte's results are written into a queue entry and then loaded into the output
// registers before the output channel offers the first of them.
// Throughput: one byte per cycle; a byte that yields n results sends them out one
// at a time, and input stalls once the four-run queue fills.
// Lead and continuation bytes that complete nothing produce no output item.
// Reset clears the sequence state, the queue and the output stage at once.
module utf8_validating_decoder
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    utf8d_byte_if.sink  in_ch,
    utf8d_cp_if.source  out_ch
);

    q_push_t q_push;
    q_stat_t q_stat;
    logic    pop;

    utf8d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_stat (q_stat),
        .q_push (q_push)
    );

    utf8d_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_stat (q_stat)
    );

    utf8d_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule
